@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL. Every macro samples on clk_i and is
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lskv_pkg.sv @@
package lskv_pkg;

  // Default number of table entries.
  localparam int unsigned DEFAULT_CAPACITY = 16;

  // Field widths.
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned TOTAL_W  = 5;
  localparam int unsigned STATUS_W = 2;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [VALUE_W-1:0] value_t;

  // Request modes. Codes five to seven behave as a lookup.
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ACCESS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

  // Update commands broadcast from the controller to every cell.
  typedef struct packed {
    logic shift;   // close the gap left by a deleted entry
    logic update;  // overwrite the value of the matching entry
    logic append;  // store the request at the tail entry
  } lskv_ctl_t;

endpackage

@@ rtl/lskv_cell.sv @@
module lskv_cell #(
  parameter int unsigned IDX     = 0,
  parameter int unsigned COUNT_W = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmp_en_i,
  input  lskv_pkg::lskv_ctl_t ctl_i,
  input  logic [COUNT_W-1:0] count_i,
  input  lskv_pkg::key_t     req_key_i,
  input  lskv_pkg::value_t   wr_value_i,
  input  lskv_pkg::key_t     nbr_key_i,
  input  lskv_pkg::value_t   nbr_value_i,
  input  logic               hit_i,
  output lskv_pkg::key_t     key_o,
  output lskv_pkg::value_t   value_o,
  output logic               hit_o,
  output logic               match_o,
  output lskv_pkg::value_t   sel_value_o
);
  import lskv_pkg::*;

  key_t   key_q;
  value_t value_q;
  logic   match_q;
  logic   live;
  logic   at_tail;

  // This entry is in use while its index is below the entry count.
  assign live    = COUNT_W'(IDX) < count_i;
  assign at_tail = count_i == COUNT_W'(IDX);

  // Compare the stored key against the request key.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (cmp_en_i) begin
      match_q <= live && (key_q == req_key_i);
    end
  end

  // The hit flag ripples along the row: set at the match and past it.
  assign hit_o       = hit_i | match_q;
  assign match_o     = match_q;
  assign sel_value_o = match_q ? value_q : '0;
  assign key_o       = key_q;
  assign value_o     = value_q;

  // Entry update: shift down on delete, overwrite on write, fill on append.
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift && hit_o) begin
      key_q   <= nbr_key_i;
      value_q <= nbr_value_i;
    end else if (ctl_i.update && match_q) begin
      value_q <= wr_value_i;
    end else if (ctl_i.append && at_tail) begin
      key_q   <= req_key_i;
      value_q <= wr_value_i;
    end
  end

endmodule

@@ rtl/linear_search_key_value_table.sv @@
// A result beat is registered after the request passes the compare state of the cell
// row and then the update state that writes the cells and the result register; a new
// request is taken only while idle or in the update state of the request before it.
// A waiting result stalls only the update cycle; the next request is taken with it.
// Reset (rst_ni low, asynchronous) empties the table and drops any pending result.
`include "assert_macros.svh"

module linear_search_key_value_table #(
  parameter int unsigned CAPACITY = lskv_pkg::DEFAULT_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] key, [63:32] new_value
  input  logic [63:0] s_axis_tdata,
  // [2:0] mode
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] read_value, [36:32] entry_total, [39:37] zero
  output logic [39:0] m_axis_tdata,
  // [0] found, [2:1] status
  output logic [2:0]  m_axis_tuser
);
  import lskv_pkg::*;

  localparam int unsigned CountW = $clog2(CAPACITY + 1);
  localparam int unsigned ExtW   = (CountW > TOTAL_W) ? CountW : TOTAL_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_e;

  state_e             state_q;
  logic [MODE_W-1:0]  mode_q;
  key_t               key_q;
  value_t             nval_q;
  logic [CountW-1:0]  count_q;
  logic [CountW-1:0]  count_d;
  logic               out_valid_q;
  value_t             rv_q;
  value_t             rv_d;
  logic               found_q;
  logic [TOTAL_W-1:0] total_q;
  logic [STATUS_W-1:0] status_q;
  logic [STATUS_W-1:0] status_d;
  logic [ExtW-1:0]    count_ext;

  logic       in_fire;
  logic       exec_go;
  logic       hit;
  logic       has_room;
  value_t     hit_value;
  value_t     wr_value;
  lskv_ctl_t  ctl;

  key_t             key_arr   [CAPACITY];
  value_t           value_arr [CAPACITY];
  value_t           sel_arr   [CAPACITY];
  logic [CAPACITY:0] hit_chain;
  logic [CAPACITY-1:0] match_vec;

  // The update cycle runs once the result register is free or being drained.
  assign exec_go       = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE) || exec_go;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Row of cells, entry zero first.
  assign hit_chain[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t   nbr_key;
    value_t nbr_value;
    if (i + 1 < CAPACITY) begin : g_nbr
      assign nbr_key   = key_arr[i+1];
      assign nbr_value = value_arr[i+1];
    end else begin : g_last
      assign nbr_key   = key_arr[i];
      assign nbr_value = value_arr[i];
    end
    lskv_cell #(
      .IDX     (i),
      .COUNT_W (CountW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmp_en_i    (state_q == ST_CMP),
      .ctl_i       (ctl),
      .count_i     (count_q),
      .req_key_i   (key_q),
      .wr_value_i  (wr_value),
      .nbr_key_i   (nbr_key),
      .nbr_value_i (nbr_value),
      .hit_i       (hit_chain[i]),
      .key_o       (key_arr[i]),
      .value_o     (value_arr[i]),
      .hit_o       (hit_chain[i+1]),
      .match_o     (match_vec[i]),
      .sel_value_o (sel_arr[i])
    );
  end

  assign hit = hit_chain[CAPACITY];

  // At most one cell matches, so an OR of the gated values selects it.
  always_comb begin
    hit_value = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      hit_value = hit_value | sel_arr[i];
    end
  end

  // Decode the request into cell commands, the new count and the result.
  assign has_room  = count_q < CountW'(CAPACITY);
  assign wr_value  = (mode_q == MODE_WRITE) ? nval_q : '0;

  always_comb begin
    ctl      = '0;
    count_d  = count_q;
    rv_d     = '0;
    status_d = STATUS_OK;
    case (mode_q)
      MODE_ACCESS, MODE_WRITE: begin
        if (hit) begin
          ctl.update = exec_go && (mode_q == MODE_WRITE);
          rv_d       = (mode_q == MODE_WRITE) ? nval_q : hit_value;
        end else if (has_room) begin
          ctl.append = exec_go;
          count_d    = count_q + 1'b1;
          rv_d       = wr_value;
        end else begin
          status_d = STATUS_FULL;
        end
      end
      MODE_DELETE: begin
        if (hit) begin
          ctl.shift = exec_go;
          count_d   = count_q - 1'b1;
        end else begin
          status_d = STATUS_ABSENT;
        end
      end
      MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
        rv_d = hit ? hit_value : '0;
      end
    endcase
  end

  assign count_ext = ExtW'(count_d);

  // Controller state, entry count and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec_go) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (exec_go) begin
            state_q <= in_fire ? ST_CMP : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= s_axis_tuser;
      key_q  <= s_axis_tdata[KEY_W-1:0];
      nval_q <= s_axis_tdata[KEY_W+VALUE_W-1:KEY_W];
    end
    if (exec_go) begin
      rv_q     <= rv_d;
      found_q  <= hit;
      total_q  <= count_ext[TOTAL_W-1:0];
      status_q <= status_d;
    end
  end

  // Result beat.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, total_q, rv_q};
  assign m_axis_tuser  = {status_q, found_q};

  // Checks on the table logic.
  `ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CountW'(CAPACITY), "entry count above capacity")
  `ASSERT_IMPL(a_single_match, state_q == ST_EXEC, $onehot0(match_vec), "several cells match")
  `ASSERT_IMPL(a_full_status, out_valid_q && (status_q == STATUS_FULL), count_q == CountW'(CAPACITY), "full status with room left")
  `ASSERT_NEXT(a_delete_count, exec_go && (mode_q == MODE_DELETE) && hit, count_q == CountW'($past(count_q) - 1'b1), "delete did not drop the count")

endmodule

@@ tb/sv/linear_search_key_value_table_tb.sv @@
module linear_search_key_value_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lskv_pkg::*;

  localparam int unsigned TABLE_DEPTH  = DEFAULT_CAPACITY;
  localparam int unsigned RANDOM_ITEMS = 1025;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 80;

  // One result beat as the block reports it.
  typedef struct packed {
    value_t               read_value;
    logic                 found;
    logic [TOTAL_W-1:0]   entry_total;
    logic [STATUS_W-1:0]  status;
  } kv_result_t;

  // Mirror of the table contents and the queue of results still owed by the block.
  class kv_table_tracker;
    key_t        keys [TABLE_DEPTH];
    value_t      vals [TABLE_DEPTH];
    int unsigned count;
    kv_result_t  expected_results[$];
    int unsigned mismatches;

    // Apply one accepted request to the mirror and queue the result it must produce.
    function void note_request(logic [MODE_W-1:0] mode, key_t key, value_t new_value);
      kv_result_t r;
      int         slot;
      bit         hit;
      slot = -1;
      for (int i = 0; i < int'(count); i++) begin
        if (slot < 0 && keys[i] == key) slot = i;
      end
      hit = (slot >= 0);
      r.read_value = '0;
      r.found      = hit;
      r.status     = STATUS_OK;
      case (mode)
        MODE_ACCESS, MODE_WRITE: begin
          if (!hit && count == TABLE_DEPTH) begin
            r.status = STATUS_FULL;
          end else begin
            if (!hit) begin
              slot       = count;
              keys[slot] = key;
              vals[slot] = '0;
              count++;
            end
            if (mode == MODE_WRITE) vals[slot] = new_value;
            r.read_value = vals[slot];
          end
        end
        MODE_DELETE: begin
          if (hit) begin
            // Later entries move down one place to keep the table compact.
            for (int j = slot; j + 1 < int'(count); j++) begin
              keys[j] = keys[j + 1];
              vals[j] = vals[j + 1];
            end
            count--;
          end else begin
            r.status = STATUS_ABSENT;
          end
        end
        MODE_CLEAR: begin
          count = 0;
        end
        default: begin
          if (hit) r.read_value = vals[slot];
        end
      endcase
      r.entry_total = TOTAL_W'(count);
      expected_results.push_back(r);
    endfunction

    // Compare one result beat against the oldest outstanding expectation.
    function void check_result(value_t read_value, logic found,
                               logic [TOTAL_W-1:0] entry_total, logic [STATUS_W-1:0] status);
      kv_result_t got;
      kv_result_t want;
      got.read_value  = read_value;
      got.found       = found;
      got.entry_total = entry_total;
      got.status      = status;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: value %h found %b total %0d status %0d",
                 $time, got.read_value, got.found, got.entry_total, got.status);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: expected value %h found %b total %0d status %0d", $time,
                   want.read_value, want.found, want.entry_total, want.status);
          $display("%0t: actual   value %h found %b total %0d status %0d", $time,
                   got.read_value, got.found, got.entry_total, got.status);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata  = '0;
  logic [MODE_W-1:0]   s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [39:0]         m_axis_tdata;
  logic [2:0]          m_axis_tuser;

  kv_table_tracker tracker;
  bit          sender_calm  = 1'b0;
  int unsigned results_seen = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  int unsigned quiet_cycles = 0;

  linear_search_key_value_table #(
    .CAPACITY(TABLE_DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Offer one request beat and wait until the block takes it. Entered and left at a
  // falling edge, so valid stays high between back-to-back beats.
  task automatic send_request(input logic [MODE_W-1:0] mode, input key_t key,
                              input value_t new_value);
    while (!sender_calm && $urandom_range(0, 99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {new_value, key};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(mode, key, new_value);
    @(negedge clk_i);
  endtask

  // Result side: random back-pressure, one long hold-off, and a stretch with none.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (results_seen >= 650 && results_seen < 850) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 16);
    end
  end

  // Check every result beat as it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(m_axis_tdata[31:0], m_axis_tuser[0], m_axis_tdata[36:32],
                           m_axis_tuser[2:1]);
      results_seen++;
    end
  end

  // Give up when neither side has moved a beat for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("linear_search_key_value_table_tb failed");
        $finish;
      end
    end
  end

  initial begin
    key_t        key_pool [24];
    key_t        fill_key;
    value_t      fill_val;
    int unsigned pool_size;
    int unsigned phase_len;
    int unsigned random_sent;
    int unsigned pick;
    logic [MODE_W-1:0] mode;
    key_t        key;

    tracker     = new();
    random_sent = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty table, fill to capacity with extreme keys and values, then the
    // full, update, unused-mode, delete and clear cases.
    send_request(MODE_LOOKUP, 32'h8000_0000, 32'h0);
    send_request(MODE_DELETE, 32'h0, 32'hffff_ffff);
    for (int i = 0; i < int'(TABLE_DEPTH); i++) begin
      case (i)
        0:       fill_key = 32'h8000_0000;
        1:       fill_key = 32'h7fff_ffff;
        2:       fill_key = 32'h0000_0000;
        3:       fill_key = 32'hffff_ffff;
        default: fill_key = 32'(i) * 32'h1357_9bdf;
      endcase
      fill_val = (i == 0) ? 32'h7fff_ffff : (i == 1) ? 32'h8000_0000 : value_t'($urandom);
      send_request(MODE_WRITE, fill_key, fill_val);
    end
    send_request(MODE_ACCESS, 32'h0000_0002, 32'h5555_5555);
    send_request(MODE_WRITE, 32'h0000_0002, 32'haaaa_aaaa);
    send_request(MODE_ACCESS, 32'h7fff_ffff, 32'h1234_5678);
    send_request(3'd5, 32'h8000_0000, 32'h0);
    send_request(3'd6, 32'h0000_0000, 32'h0);
    send_request(3'd7, 32'h0000_0002, 32'h0);
    send_request(MODE_WRITE, 32'h0000_0000, 32'hffff_ffff);
    send_request(MODE_DELETE, 32'h7fff_ffff, 32'h0);
    send_request(MODE_LOOKUP, 32'hffff_ffff, 32'h0);
    send_request(MODE_DELETE, 32'h7fff_ffff, 32'h0);
    send_request(MODE_CLEAR, 32'hffff_ffff, 32'h0);
    send_request(MODE_LOOKUP, 32'h8000_0000, 32'h0);

    // Random phases: each draws a key pool of its own size so the table sometimes
    // stays sparse and sometimes runs full; a few keys come from outside the pool.
    while (random_sent < RANDOM_ITEMS) begin
      pool_size = $urandom_range(2, 24);
      for (int i = 0; i < int'(pool_size); i++) key_pool[i] = $urandom;
      phase_len = $urandom_range(40, 120);
      for (int n = 0; n < int'(phase_len) && random_sent < RANDOM_ITEMS; n++) begin
        sender_calm = (random_sent >= 550 && random_sent < 750);
        pick = $urandom_range(0, 99);
        if (pick < 22)      mode = MODE_LOOKUP;
        else if (pick < 37) mode = MODE_ACCESS;
        else if (pick < 67) mode = MODE_WRITE;
        else if (pick < 85) mode = MODE_DELETE;
        else if (pick < 88) mode = MODE_CLEAR;
        else                mode = MODE_W'($urandom_range(5, 7));
        key = ($urandom_range(0, 9) == 0) ? key_t'($urandom)
                                          : key_pool[$urandom_range(0, pool_size - 1)];
        send_request(mode, key, $urandom);
        random_sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain the outstanding results, then keep watching for stray beats before the verdict.
    while (tracker.expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("linear_search_key_value_table_tb passed");
    end else begin
      $display("linear_search_key_value_table_tb failed");
    end
    $finish;
  end

endmodule
